### hw/rtl/djs_pkg.sv
// ----------------------------------------------------------------------------
// djs_pkg
// Shared widths, saturation limits and sequencer states for the deadline
// job sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package djs_pkg;

    localparam int DEADLINE_W = 16;
    localparam int PROFIT_W   = 16;
    localparam int SCHED_W    = 9;
    localparam int TOTAL_W    = 24;

    localparam logic [SCHED_W-1:0] SCHED_SAT = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    typedef logic [DEADLINE_W-1:0] deadline_t;
    typedef logic [PROFIT_W-1:0]   profit_t;
    typedef logic [SCHED_W-1:0]    sched_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEL_START,
        ST_SEL_RD,
        ST_SEL_CK,
        ST_PICK,
        ST_SLOT_RD,
        ST_SLOT_CK,
        ST_FINISH,
        ST_CLEAR
    } seq_state_t;

endpackage

`default_nettype wire

### hw/rtl/djs_if.sv
// ----------------------------------------------------------------------------
// djs_if
// Valid/ready channels: job input and batch result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface djs_job_if;
    import djs_pkg::*;

    logic      valid;
    logic      ready;
    deadline_t job_deadline;
    profit_t   job_profit;
    logic      last_job;

    modport source (output valid, job_deadline, job_profit, last_job, input ready);
    modport sink   (input valid, job_deadline, job_profit, last_job, output ready);
endinterface

interface djs_result_if;
    import djs_pkg::*;

    logic   valid;
    logic   ready;
    sched_t jobs_scheduled;
    total_t total_profit;
    logic   batch_overflow;

    modport source (output valid, jobs_scheduled, total_profit, batch_overflow, input ready);
    modport sink   (input valid, jobs_scheduled, total_profit, batch_overflow, output ready);
endinterface

`default_nettype wire

### hw/rtl/deadline_job_sequencer_unit.sv
// ----------------------------------------------------------------------------
// deadline_job_sequencer_unit
// Greedy job sequencing with deadlines over a batch held in RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                         Transfer
//  job      in   job_deadline, job_profit, last_job              valid & ready
//  result   out  jobs_scheduled, total_profit, batch_overflow    valid & ready
//
//  Jobs load at one per cycle into the job RAM while the unit is in its load
//  state. On the last job, each of the n+1 rounds scans all n stored jobs
//  through the job RAM port for the highest unused profit; each pick with a
//  nonzero deadline then probes the slot RAM downward from its deadline. The
//  result is registered once no job is left to pick. After each result and
//  after reset, a clear pass sweeps all MAX_JOBS slot RAM entries; no job is
//  taken meanwhile. The result register frees the input side; a batch end
//  waits only if the previous result is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_job_sequencer_unit #(
    parameter int MAX_JOBS = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    djs_job_if.sink      job,
    djs_result_if.source result
);
    import djs_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int JW = 1 + CW + PROFIT_W;

    seq_state_t state_reg, state_next;

    logic [CW-1:0]      load_count_reg, load_count_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [CW-1:0]      best_dl_reg, best_dl_next;
    profit_t            best_prof_reg, best_prof_next;
    logic [CW-1:0]      s_reg, s_next;
    sched_t             placed_reg, placed_next;
    total_t             sum_reg, sum_next;
    logic [AW-1:0]      clr_reg, clr_next;

    logic               out_valid_reg, out_valid_next;
    sched_t             out_sched_reg, out_sched_next;
    total_t             out_total_reg, out_total_next;
    logic               out_ovf_reg, out_ovf_next;

    // memory ports
    logic               jr_we, jr_re;
    logic [AW-1:0]      jr_waddr, jr_raddr;
    logic [JW-1:0]      jr_wdata, jr_rdata;
    logic               sr_we, sr_re;
    logic [AW-1:0]      sr_waddr, sr_raddr;
    logic [0:0]         sr_wdata, sr_rdata;

    logic               in_xfer, out_free;
    logic [CW-1:0]      dl_clamp, slot_idx;
    logic               rd_used, better;
    logic [CW-1:0]      rd_dl;
    profit_t            rd_prof;
    logic [TOTAL_W:0]   sum_wide;

    djs_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job_ram (
        .clk   (clk),
        .we    (jr_we),
        .waddr (jr_waddr),
        .wdata (jr_wdata),
        .re    (jr_re),
        .raddr (jr_raddr),
        .rdata (jr_rdata)
    );

    djs_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_slot_ram (
        .clk   (clk),
        .we    (sr_we),
        .waddr (sr_waddr),
        .wdata (sr_wdata),
        .re    (sr_re),
        .raddr (sr_raddr),
        .rdata (sr_rdata)
    );

    // handshake and decode helpers
    assign in_xfer  = job.valid && job.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign dl_clamp = (32'(job.job_deadline) > 32'(MAX_JOBS)) ? CW'(MAX_JOBS)
                                                              : CW'(job.job_deadline);
    assign slot_idx = s_reg - CW'(1);
    assign rd_used  = jr_rdata[JW-1];
    assign rd_dl    = jr_rdata[JW-2:PROFIT_W];
    assign rd_prof  = jr_rdata[PROFIT_W-1:0];
    assign better   = !rd_used && (!found_reg || (rd_prof > best_prof_reg));
    assign sum_wide = {1'b0, sum_reg} + (TOTAL_W+1)'(best_prof_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && job.last_job)
                begin
                    state_next = ST_SEL_START;
                end
            end
            ST_SEL_START: state_next = ST_SEL_RD;
            ST_SEL_RD:    state_next = ST_SEL_CK;
            ST_SEL_CK:
            begin
                if (k_reg + CW'(1) == load_count_reg)
                begin
                    state_next = (found_reg || better) ? ST_PICK : ST_FINISH;
                end
                else
                begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_PICK:
            begin
                state_next = (best_dl_reg == '0) ? ST_SEL_START : ST_SLOT_RD;
            end
            ST_SLOT_RD: state_next = ST_SLOT_CK;
            ST_SLOT_CK:
            begin
                if (sr_rdata == 1'b0 || slot_idx == '0)
                begin
                    state_next = ST_SEL_START;
                end
                else
                begin
                    state_next = ST_SLOT_RD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_JOBS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // memory controls and ready
    always_comb
    begin
        job.ready = 1'b0;
        jr_we     = 1'b0;
        jr_waddr  = load_count_reg[AW-1:0];
        jr_wdata  = {1'b0, dl_clamp, job.job_profit};
        jr_re     = 1'b0;
        jr_raddr  = k_reg[AW-1:0];
        sr_we     = 1'b0;
        sr_waddr  = slot_idx[AW-1:0];
        sr_wdata  = 1'b1;
        sr_re     = 1'b0;
        sr_raddr  = slot_idx[AW-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                job.ready = 1'b1;
                jr_we     = in_xfer && (load_count_reg != CW'(MAX_JOBS));
            end
            ST_SEL_RD:  jr_re = 1'b1;
            ST_PICK:
            begin
                jr_we    = 1'b1;
                jr_waddr = best_idx_reg;
                jr_wdata = {1'b1, best_dl_reg, best_prof_reg};
            end
            ST_SLOT_RD: sr_re = 1'b1;
            ST_SLOT_CK: sr_we = (sr_rdata == 1'b0);
            ST_CLEAR:
            begin
                sr_we    = 1'b1;
                sr_waddr = clr_reg;
                sr_wdata = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        load_count_next = load_count_reg;
        ovf_next        = ovf_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_prof_next  = best_prof_reg;
        s_next          = s_reg;
        placed_next     = placed_reg;
        sum_next        = sum_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_sched_next  = out_sched_reg;
        out_total_next  = out_total_reg;
        out_ovf_next    = out_ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (load_count_reg != CW'(MAX_JOBS))
                    begin
                        load_count_next = load_count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SEL_START:
            begin
                k_next     = '0;
                found_next = 1'b0;
            end
            ST_SEL_CK:
            begin
                // first strictly larger profit wins, so ties keep arrival order
                if (better)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = k_reg[AW-1:0];
                    best_dl_next   = rd_dl;
                    best_prof_next = rd_prof;
                end
                k_next = k_reg + CW'(1);
            end
            ST_PICK: s_next = best_dl_reg;
            ST_SLOT_CK:
            begin
                if (sr_rdata == 1'b0)
                begin
                    if (placed_reg != SCHED_SAT)
                    begin
                        placed_next = placed_reg + SCHED_W'(1);
                    end
                    sum_next = sum_wide[TOTAL_W] ? TOTAL_SAT : sum_wide[TOTAL_W-1:0];
                end
                else
                begin
                    s_next = slot_idx;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sched_next  = placed_reg;
                    out_total_next  = sum_reg;
                    out_ovf_next    = ovf_reg;
                    placed_next     = '0;
                    sum_next        = '0;
                    load_count_next = '0;
                    ovf_next        = 1'b0;
                    clr_next        = '0;
                end
            end
            ST_CLEAR: clr_next = clr_reg + AW'(1);
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            load_count_reg <= '0;
            ovf_reg        <= 1'b0;
            placed_reg     <= '0;
            sum_reg        <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            k_reg          <= '0;
            s_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            ovf_reg        <= ovf_next;
            placed_reg     <= placed_next;
            sum_reg        <= sum_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            k_reg          <= k_next;
            s_reg          <= s_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dl_reg   <= best_dl_next;
        best_prof_reg <= best_prof_next;
        out_sched_reg <= out_sched_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.jobs_scheduled = out_sched_reg;
    assign result.total_profit   = out_total_reg;
    assign result.batch_overflow = out_ovf_reg;

endmodule

`default_nettype wire

### hw/rtl/djs_ram.sv
// ----------------------------------------------------------------------------
// djs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module djs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks deadline_job_sequencer_unit. Batches of jobs are sent over the job
// channel and each batch result is compared with a greedy schedule worked
// out here. Directed batches come first, then one oversized batch, then
// random batches. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import djs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_JOBS    = 256;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  RANDOM_JOBS = 540;
    localparam int  SETTLE      = MAX_JOBS + 64;

    typedef struct {
        sched_t jobs_scheduled;
        total_t total_profit;
        logic   batch_overflow;
    } batch_result_t;

    typedef struct {
        deadline_t deadline;
        profit_t   profit;
        logic      last;
        logic      typed;
        sched_t    jobs_scheduled;
        total_t    total_profit;
        logic      batch_overflow;
    } job_row_t;

    logic clk;
    logic rst_n;
    djs_job_if    job ();
    djs_result_if result ();

    deadline_job_sequencer_unit #(
        .MAX_JOBS(MAX_JOBS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job),
        .result(result)
    );

    // Batch state of the predictor
    int            batch_deadline [MAX_JOBS];
    int            batch_profit [MAX_JOBS];
    int            batch_loaded;
    logic          batch_dropped;
    batch_result_t expected_results [$];
    int            mismatches;
    int            cycle_count;
    logic          idle_enable;

    // Directed batches: extremes, zero deadline, clamping, equal profits
    job_row_t directed_jobs [16] = '{
        '{16'd0,     16'd65535, 1'b1, 1'b1, 9'd0, 24'd0,      1'b0},
        '{16'd65535, 16'd65535, 1'b1, 1'b1, 9'd1, 24'd65535,  1'b0},
        '{16'd1,     16'd0,     1'b1, 1'b1, 9'd1, 24'd0,      1'b0},
        '{16'd2,     16'd100,   1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd2,     16'd100,   1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd2,     16'd100,   1'b1, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd300,   16'd5,     1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd65535, 16'd7,     1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd1,     16'd9,     1'b1, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd3,     16'd65535, 1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd2,     16'd65535, 1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd1,     16'd65535, 1'b1, 1'b1, 9'd3, 24'd196605, 1'b0},
        '{16'd0,     16'd50,    1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd1,     16'd10,    1'b0, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd1,     16'd20,    1'b1, 1'b0, 9'd0, 24'd0,      1'b0},
        '{16'd32768, 16'd32768, 1'b1, 1'b1, 9'd1, 24'd32768,  1'b0}
    };

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_enable || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Greedy schedule of the loaded batch: descending profit, stable on ties
    function automatic batch_result_t schedule_batch();
        batch_result_t res;
        int   order [MAX_JOBS];
        logic taken [MAX_JOBS + 1];
        int   i;
        int   j;
        int   key;
        int   s;
        int   count;
        int   total;
        for (i = 0; i <= MAX_JOBS; i++)
            taken[i] = 1'b0;
        for (i = 0; i < batch_loaded; i++)
        begin
            key = i;
            j = i;
            while (j > 0 && batch_profit[order[j - 1]] < batch_profit[key])
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = key;
        end
        count = 0;
        total = 0;
        for (i = 0; i < batch_loaded; i++)
        begin
            s = batch_deadline[order[i]];
            while (s > 0 && taken[s])
                s--;
            if (s > 0)
            begin
                taken[s] = 1'b1;
                if (count < int'(SCHED_SAT))
                    count++;
                total += batch_profit[order[i]];
                if (total > int'(TOTAL_SAT))
                    total = int'(TOTAL_SAT);
            end
        end
        res.jobs_scheduled = sched_t'(count);
        res.total_profit   = total_t'(total);
        res.batch_overflow = batch_dropped;
        return res;
    endfunction

    // Load one accepted job; returns the batch result when it ends the batch
    function automatic void load_job(deadline_t d, profit_t p, logic l,
                                     output batch_result_t res);
        int dl;
        dl = (int'(d) > MAX_JOBS) ? MAX_JOBS : int'(d);
        if (batch_loaded < MAX_JOBS)
        begin
            batch_deadline[batch_loaded] = dl;
            batch_profit[batch_loaded] = int'(p);
            batch_loaded++;
        end
        else
            batch_dropped = 1'b1;
        res = '{default: '0};
        if (l)
        begin
            res = schedule_batch();
            batch_loaded = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    // Drive one job transfer; entered and left at a falling edge
    task automatic send_job(deadline_t d, profit_t p, logic l, logic typed,
                            batch_result_t typed_res);
        int            gap;
        batch_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            job.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        job.valid        <= 1'b1;
        job.job_deadline <= d;
        job.job_profit   <= p;
        job.last_job     <= l;
        do
            @(posedge clk);
        while (!job.ready);
        load_job(d, p, l, res);
        if (l)
            expected_results = {expected_results, typed ? typed_res : res};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        job.valid <= 1'b0;
        while (expected_results.size() > 0)
            @(negedge clk);
    endtask

    // Random ready on the result side
    always @(negedge clk)
    begin
        int stall;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            stall = pick_gap();
            result.ready <= (stall == 0);
        end
    end

    // Result checking
    always @(posedge clk)
    begin
        batch_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %0d %0d %0b",
                             result.jobs_scheduled, result.total_profit,
                             result.batch_overflow);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.jobs_scheduled !== want.jobs_scheduled ||
                    result.total_profit !== want.total_profit ||
                    result.batch_overflow !== want.batch_overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want.jobs_scheduled, want.total_profit,
                                 want.batch_overflow, result.jobs_scheduled,
                                 result.total_profit, result.batch_overflow);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        batch_result_t typed_res;
        int            sent;
        int            n;
        int            k;
        int            roll;
        deadline_t     d;
        profit_t       p;
        mismatches = 0;
        cycle_count = 0;
        batch_loaded = 0;
        batch_dropped = 1'b0;
        idle_enable = 1'b1;
        rst_n = 1'b0;
        job.valid = 1'b0;
        job.job_deadline = '0;
        job.job_profit = '0;
        job.last_job = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (directed_jobs[i])
        begin
            typed_res.jobs_scheduled = directed_jobs[i].jobs_scheduled;
            typed_res.total_profit   = directed_jobs[i].total_profit;
            typed_res.batch_overflow = directed_jobs[i].batch_overflow;
            send_job(directed_jobs[i].deadline, directed_jobs[i].profit,
                     directed_jobs[i].last, directed_jobs[i].typed, typed_res);
        end
        wait_drained();

        // Oversized batch: extras dropped, marked last job too
        idle_enable = 1'b0;
        for (k = 0; k < MAX_JOBS + 2; k++)
            send_job(deadline_t'($urandom_range(0, MAX_JOBS + 40)),
                     profit_t'($urandom), k == MAX_JOBS + 1, 1'b0, typed_res);
        wait_drained();
        idle_enable = 1'b1;

        // Random batches, mostly small
        sent = 0;
        while (sent < RANDOM_JOBS)
        begin
            roll = $urandom_range(0, 99);
            n = (roll < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            if ($urandom_range(0, 9) == 0)
                idle_enable = !idle_enable;
            for (k = 0; k < n; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    d = deadline_t'($urandom_range(0, n + 2));
                else
                    d = deadline_t'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    p = profit_t'($urandom_range(0, 7));
                else
                    p = profit_t'($urandom);
                send_job(d, p, k == n - 1, 1'b0, typed_res);
            end
            sent += n;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/djs_pkg.sv
hw/rtl/djs_if.sv
hw/rtl/djs_ram.sv
hw/rtl/deadline_job_sequencer_unit.sv
verif/testbench.sv
